### sv/difference_chain_code_encoder_top_macros.svh
// Assertion macros for the difference chain code encoder checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DIFFERENCE_CHAIN_CODE_ENCODER_TOP_MACROS_SVH
`define DIFFERENCE_CHAIN_CODE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCCE_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dcce: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define DCCE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dcce: next-cycle property failed");

`endif

### sv/dcce_pkg.sv
// Shared types and constants of the difference chain code encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dcce_pkg;

  // Coordinate width
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned CODE_BITS  = 3;

  // Input item: one contour point
  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  contour_start;
  } in_item_t;

  // Result item: one chain code
  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 is_first_code;
    logic                 step_error;
    logic                 last_of_run;
  } out_item_t;

  // Encoder state carried from point to point
  typedef struct packed {
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    logic [CODE_BITS-1:0]  prev_code;
    logic                  have_code;
    logic                  have_point;
  } dcce_state_t;

  // Results of one point: count (0..2) and up to two items
  typedef struct packed {
    logic [1:0] num;
    out_item_t  res0;
    out_item_t  res1;
  } step_res_t;

endpackage

`default_nettype wire

### sv/dcce_step.sv
// Per-point logic: step classification, direction lookup, diagonal split
// and code differencing. Pure combinational; depends on dcce_pkg.
`default_nettype none

module dcce_step (
  input  dcce_pkg::in_item_t    item_i,
  input  dcce_pkg::dcce_state_t state_i,
  input  logic                  four_conn_i,
  output dcce_pkg::step_res_t   res_o,
  output dcce_pkg::dcce_state_t state_o
);
  import dcce_pkg::*;

  // Step index along one axis
  localparam logic [1:0] IDX_NEG  = 2'd0;
  localparam logic [1:0] IDX_ZERO = 2'd1;
  localparam logic [1:0] IDX_POS  = 2'd2;
  localparam logic [1:0] IDX_FAR  = 2'd3;

  // Classify cur - prev as -1, 0, +1 or anything else
  function automatic logic [1:0] delta_idx(logic [COORD_BITS-1:0] cur,
                                           logic [COORD_BITS-1:0] prv);
    logic [COORD_BITS:0] cur_e;
    logic [COORD_BITS:0] prv_e;
    logic [1:0]          idx;
    cur_e = {1'b0, cur};
    prv_e = {1'b0, prv};
    if (cur_e == prv_e) begin
      idx = IDX_ZERO;
    end else if (cur_e == prv_e + (COORD_BITS+1)'(1)) begin
      idx = IDX_POS;
    end else if (prv_e == cur_e + (COORD_BITS+1)'(1)) begin
      idx = IDX_NEG;
    end else begin
      idx = IDX_FAR;
    end
    return idx;
  endfunction

  // Freeman direction of a valid neighbour step
  function automatic logic [CODE_BITS-1:0] dir_code(logic [1:0] ix, logic [1:0] iy);
    logic [CODE_BITS-1:0] c;
    case ({ix, iy})
      {IDX_NEG,  IDX_NEG }: c = 3'd7;
      {IDX_NEG,  IDX_ZERO}: c = 3'd0;
      {IDX_NEG,  IDX_POS }: c = 3'd1;
      {IDX_ZERO, IDX_NEG }: c = 3'd6;
      {IDX_ZERO, IDX_POS }: c = 3'd2;
      {IDX_POS,  IDX_NEG }: c = 3'd5;
      {IDX_POS,  IDX_ZERO}: c = 3'd4;
      {IDX_POS,  IDX_POS }: c = 3'd3;
      default:              c = 3'd0;
    endcase
    return c;
  endfunction

  logic [1:0]           ix;
  logic [1:0]           iy;
  logic                 bad_step;
  logic [CODE_BITS-1:0] c;
  logic [CODE_BITS-1:0] code_a;
  logic [CODE_BITS-1:0] code_b;
  logic                 split;

  // Classify the step
  assign ix       = delta_idx(item_i.point_x, state_i.prev_x);
  assign iy       = delta_idx(item_i.point_y, state_i.prev_y);
  assign bad_step = (ix == IDX_FAR) || (iy == IDX_FAR) ||
                    ((ix == IDX_ZERO) && (iy == IDX_ZERO));
  assign c        = dir_code(ix, iy);
  assign split    = four_conn_i && c[0];
  assign code_a   = c + 3'd1;
  assign code_b   = c - 3'd1;

  // Build results and next state
  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (item_i.contour_start || !state_i.have_point) begin
      // New origin, no result
      state_o.prev_x     = item_i.point_x;
      state_o.prev_y     = item_i.point_y;
      state_o.have_point = 1'b1;
      state_o.have_code  = 1'b0;
    end else if (bad_step) begin
      // Error result, state held
      res_o.num              = 2'd1;
      res_o.res0.step_error  = 1'b1;
      res_o.res0.last_of_run = 1'b1;
    end else begin
      state_o.prev_x    = item_i.point_x;
      state_o.prev_y    = item_i.point_y;
      state_o.have_code = 1'b1;
      if (split) begin
        // Diagonal as two axis codes; the second follows the first
        res_o.num                = 2'd2;
        res_o.res0.code          = state_i.have_code ? code_a - state_i.prev_code : code_a;
        res_o.res0.is_first_code = !state_i.have_code;
        res_o.res1.code          = code_b - code_a;
        res_o.res1.last_of_run   = 1'b1;
        state_o.prev_code        = code_b;
      end else begin
        res_o.num                = 2'd1;
        res_o.res0.code          = state_i.have_code ? c - state_i.prev_code : c;
        res_o.res0.is_first_code = !state_i.have_code;
        res_o.res0.last_of_run   = 1'b1;
        state_o.prev_code        = c;
      end
    end
  end

endmodule

`default_nettype wire

### sv/dcce_out_buf.sv
// Two-entry result register: loads one or two items at once and sends one a
// cycle while out_stall_i is low. Depends on dcce_pkg.
`default_nettype none

module dcce_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  dcce_pkg::step_res_t   res_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dcce_pkg::out_item_t   out_item_o
);
  import dcce_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  out_item_t  slot0_q, slot0_d;
  out_item_t  slot1_q, slot1_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot0_q;
  assign pop         = out_valid_o && !out_stall_i;
  // Take new results when empty or when the last held item leaves now
  assign ready_o     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  // Load, or advance the second slot on a pop
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load_i) begin
      cnt_d   = res_i.num;
      slot0_d = res_i.res0;
      slot1_d = res_i.res1;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  // Hold the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the items
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

### sv/difference_chain_code_encoder_top.sv
// Difference chain code encoder: contour points in, difference chain codes out.
// Channels: point items on in_valid_i / in_stall_o, code items on
// out_valid_o / out_stall_i, an item moving at an edge with valid high and
// stall low. The four_connected mode bit is written through cfg_valid_i /
// cfg_ready_o / cfg_data_i and must only change while the block is idle.
// Path: an accepted point is decoded in the input register; its first code
// is loaded into the result register and from there shows on out_item_o.
// Throughput: one point per cycle when out_stall_i is low; a diagonal step
// in four-connected mode gives two codes, and the next point that leaves a
// code waits in the input register until the second one leaves. A contour
// start or a point that leaves no code skips the result register.
// Stall: while out_stall_i holds an item in the result register, a held
// point that leaves a code stays and in_stall_o rises in the same cycle.
// Reset: rst_ni clears the mode bit, the previous point and code, and both
// registers' valid flags; the first point after reset becomes an origin.
// Depends on dcce_pkg, dcce_step and dcce_out_buf.
`default_nettype none

module difference_chain_code_encoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dcce_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dcce_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import dcce_pkg::*;

  logic        in_vld_q, in_vld_d;
  in_item_t    in_q;
  logic        four_conn_q;
  dcce_state_t state_q, state_d;
  step_res_t   step_res;
  logic        buf_ready;
  logic        consume;
  logic        in_accept;

  // Retire the held point when its results fit into the result register
  assign consume    = in_vld_q && ((step_res.num == 2'd0) || buf_ready);
  assign in_stall_o = in_vld_q && !consume;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_accept || (in_vld_q && !consume);

  assign cfg_ready_o = 1'b1;

  // Input register valid and mode bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      four_conn_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_valid_i) begin
        four_conn_q <= cfg_data_i;
      end
    end
  end

  // Input payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  // Encoder state advances with each retired point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (consume) begin
      state_q <= state_d;
    end
  end

  dcce_step u_step (
    .item_i      (in_q),
    .state_i     (state_q),
    .four_conn_i (four_conn_q),
    .res_o       (step_res),
    .state_o     (state_d)
  );

  dcce_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume && (step_res.num != 2'd0)),
    .res_i       (step_res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### sv/dcce_checker.sv
// Port-level checks of the difference chain code encoder, bound to the top.
// Depends on dcce_pkg and difference_chain_code_encoder_top_macros.svh.
`default_nettype none
`include "difference_chain_code_encoder_top_macros.svh"

module dcce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dcce_pkg::out_item_t out_item_o
);
  import dcce_pkg::*;

  logic out_pop;
  assign out_pop = out_valid_o && !out_stall_i;

  // A stalled result item stays put
  `DCCE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // An error item carries a zero code and closes its point
  `DCCE_ASSERT_NOW(a_err_shape, out_valid_o && out_item_o.step_error,
                   out_item_o.code == '0 && out_item_o.last_of_run && !out_item_o.is_first_code)

  // The second code of a split diagonal is already buffered
  `DCCE_ASSERT_NEXT(a_pair_follows, out_pop && !out_item_o.last_of_run, out_valid_o)

  // The second code of a pair is a differenced axis turn, never an error
  `DCCE_ASSERT_NEXT(a_pair_second, out_pop && !out_item_o.last_of_run,
                    !out_item_o.is_first_code && !out_item_o.step_error &&
                    out_item_o.last_of_run && out_item_o.code == 3'd6)

endmodule

bind difference_chain_code_encoder_top dcce_checker u_dcce_checker (.*);

`default_nettype wire
